// ===== src/sird_pkg.sv =====
// shared types, constants and helpers for the signed integer to radix digits block
`default_nettype none

package sird_pkg;

    localparam int NUM_W      = 32;
    localparam int CHAR_W     = 8;
    localparam int SYM_SLOTS  = 16;
    localparam int DIGIT_W    = 4;
    localparam int RADIX_W    = 5;
    localparam int MAX_DIGITS = 32;
    localparam int DCNT_W     = 6;
    localparam int DIDX_W     = 5;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 64;

    typedef logic [NUM_W-1:0]      num_t;
    typedef logic [CHAR_W-1:0]     char_t;
    typedef logic [DIGIT_W-1:0]    digit_t;
    typedef logic [RADIX_W-1:0]    radix_t;
    typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
    typedef logic [CFG_DATA_W-1:0] cfg_data_t;

    // register indexes
    localparam cfg_idx_t REG_SYMBOLS_LOW  = 8'd0;
    localparam cfg_idx_t REG_SYMBOLS_HIGH = 8'd1;

    // special characters
    localparam char_t CHAR_PLUS  = 8'h2B;
    localparam char_t CHAR_MINUS = 8'h2D;
    localparam char_t CHAR_NUL   = 8'h00;

    // divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // symbol byte k of the alphabet
    function automatic char_t symbol_at(cfg_data_t sym_low, cfg_data_t sym_high, digit_t k);
        char_t s;
        if (k[3] == 1'b0)
        begin
            s = sym_low[8*k[2:0] +: 8];
        end
        else
        begin
            s = sym_high[8*k[2:0] +: 8];
        end
        return s;
    endfunction

endpackage

`default_nettype wire

// ===== src/sird_num_if.sv =====
// input channel carrying one number per word
`default_nettype none

interface sird_num_if;
    import sird_pkg::*;

    logic valid;
    logic ready;
    num_t number_value;

    modport source (output valid, output number_value, input ready);
    modport sink   (input valid, input number_value, output ready);
endinterface

`default_nettype wire

// ===== src/sird_char_if.sv =====
// output channel carrying one text character per word
`default_nettype none

interface sird_char_if;
    import sird_pkg::*;

    logic  valid;
    logic  ready;
    char_t text_char;
    logic  final_char;

    modport source (output valid, output text_char, output final_char, input ready);
    modport sink   (input valid, input text_char, input final_char, output ready);
endinterface

`default_nettype wire

// ===== src/sird_cfg_if.sv =====
// configuration write channel
`default_nettype none

interface sird_cfg_if;
    import sird_pkg::*;

    logic      valid;
    logic      ready;
    cfg_idx_t  index;
    cfg_data_t data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== src/sird_alpha.sv =====
// alphabet check: length up to the first zero byte, sign symbols and duplicates
`default_nettype none

module sird_alpha
    import sird_pkg::*;
#(
    parameter int MAX_SYMBOLS = 16
)
(
    input  wire cfg_data_t sym_low,
    input  wire cfg_data_t sym_high,
    output radix_t         radix
);

    char_t                sym      [SYM_SLOTS];
    logic [SYM_SLOTS-1:0] nonzero;
    logic [SYM_SLOTS-1:0] in_alpha;
    radix_t               len;
    logic                 bad;

    // unpack the symbol bytes
    always_comb
    begin
        for (int i = 0; i < SYM_SLOTS; i++)
        begin
            sym[i]     = symbol_at(sym_low, sym_high, DIGIT_W'(i));
            nonzero[i] = (sym[i] != CHAR_NUL) && (i < MAX_SYMBOLS);
        end
    end

    // a slot belongs to the alphabet when it and all slots below are nonzero
    always_comb
    begin
        for (int i = 0; i < SYM_SLOTS; i++)
        begin
            in_alpha[i] = &(nonzero | ~(SYM_SLOTS'((2**(i+1)) - 1)));
        end
    end

    // length and validity
    always_comb
    begin
        len = '0;
        bad = 1'b0;
        for (int i = 0; i < SYM_SLOTS; i++)
        begin
            len = len + RADIX_W'(in_alpha[i]);
            if (in_alpha[i] && (sym[i] == CHAR_PLUS || sym[i] == CHAR_MINUS))
            begin
                bad = 1'b1;
            end
            for (int j = i + 1; j < SYM_SLOTS; j++)
            begin
                if (in_alpha[j] && sym[i] == sym[j])
                begin
                    bad = 1'b1;
                end
            end
        end
        if (bad || len < RADIX_W'(2))
        begin
            radix = '0;
        end
        else
        begin
            radix = len;
        end
    end

endmodule

`default_nettype wire

// ===== src/sird_div.sv =====
// restoring divider, one quotient bit per cycle, small divisor
`default_nettype none

module sird_div
    import sird_pkg::*;
(
    input  wire        clk,
    input  wire        rst_n,
    input  wire        start,
    input  wire num_t  dividend,
    input  wire radix_t divisor,
    output num_t       quotient,
    output digit_t     remainder,
    output div_stat_t  stat
);

    num_t              q_reg;
    digit_t            r_reg;
    logic [DIDX_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [RADIX_W-1:0] trial;
    logic               fits;

    // one trial subtraction
    always_comb
    begin
        trial = {r_reg, q_reg[NUM_W-1]};
        fits  = (trial >= divisor);
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIDX_W'(NUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= dividend;
            r_reg <= '0;
        end
        else if (busy_reg)
        begin
            q_reg <= {q_reg[NUM_W-2:0], fits};
            if (fits)
            begin
                r_reg <= DIGIT_W'(trial - divisor);
            end
            else
            begin
                r_reg <= DIGIT_W'(trial);
            end
        end
    end

    assign quotient  = q_reg;
    assign remainder = r_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

`default_nettype wire

// ===== src/signed_int_to_radix_digits_top.sv =====
// top level: configuration registers, digit sequencer and character output
// Formats a signed 32-bit number as text in the radix given by the digit alphabet held in two
// configuration registers, one character per output word, most significant digit first, with
// final_char on the last word; a negative number starts with '-'. An invalid alphabet (length
// below two, a '+' or '-' symbol, or a repeated symbol) makes the number produce no words.
// Each digit comes from the shared bit-serial divider (start, all quotient bits, result pickup),
// so a number is busy with all of its digits before its characters, then gives one character
// per cycle while text_out is ready.
// num_in is ready only between numbers. Configuration words are always accepted.
`default_nettype none

module signed_int_to_radix_digits_top
    import sird_pkg::*;
#(
    parameter int MAX_SYMBOLS = 16
)
(
    input  wire         clk,
    input  wire         rst_n,
    sird_num_if.sink    num_in,
    sird_char_if.source text_out,
    sird_cfg_if.sink    cfg
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_WAIT,
        ST_SIGN,
        ST_EMIT
    } state_t;

    state_t            state_reg;
    cfg_data_t         sym_low_reg;
    cfg_data_t         sym_high_reg;
    radix_t            radix_reg;
    logic              neg_reg;
    num_t              mag_reg;
    logic [DCNT_W-1:0] nd_reg;
    logic [DIDX_W-1:0] rd_reg;
    digit_t            digits_reg [MAX_DIGITS];

    radix_t            radix_now;
    num_t              quotient;
    digit_t            remainder;
    div_stat_t         div_stat;
    logic              div_start;
    logic              in_take;
    logic              out_take;

    // alphabet check
    sird_alpha #(
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_alpha (
        .sym_low  (sym_low_reg),
        .sym_high (sym_high_reg),
        .radix    (radix_now)
    );

    // shared divider
    sird_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (mag_reg),
        .divisor   (radix_reg),
        .quotient  (quotient),
        .remainder (remainder),
        .stat      (div_stat)
    );

    // handshakes
    assign cfg.ready     = 1'b1;
    assign num_in.ready  = (state_reg == ST_IDLE);
    assign in_take       = num_in.valid && num_in.ready;
    assign out_take      = text_out.valid && text_out.ready;
    assign div_start     = (state_reg == ST_START);

    // output word
    assign text_out.valid      = (state_reg == ST_SIGN) || (state_reg == ST_EMIT);
    assign text_out.text_char  = (state_reg == ST_SIGN) ? CHAR_MINUS
                               : symbol_at(sym_low_reg, sym_high_reg, digits_reg[rd_reg]);
    assign text_out.final_char = (state_reg == ST_EMIT) && (rd_reg == '0);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sym_low_reg  <= '0;
            sym_high_reg <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                REG_SYMBOLS_LOW:  sym_low_reg  <= cfg.data;
                REG_SYMBOLS_HIGH: sym_high_reg <= cfg.data;
                default:          ;
            endcase
        end
    end

    // digit store
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_WAIT && div_stat.done)
        begin
            digits_reg[nd_reg[DIDX_W-1:0]] <= remainder;
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            radix_reg <= '0;
            neg_reg   <= 1'b0;
            mag_reg   <= '0;
            nd_reg    <= '0;
            rd_reg    <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_take && radix_now != '0)
                    begin
                        radix_reg <= radix_now;
                        neg_reg   <= num_in.number_value[NUM_W-1];
                        mag_reg   <= num_in.number_value[NUM_W-1] ? (~num_in.number_value + 1'b1)
                                                                  : num_in.number_value;
                        nd_reg    <= '0;
                        state_reg <= ST_START;
                    end
                end
                ST_START:
                begin
                    state_reg <= ST_WAIT;
                end
                ST_WAIT:
                begin
                    if (div_stat.done)
                    begin
                        nd_reg  <= nd_reg + 1'b1;
                        mag_reg <= quotient;
                        rd_reg  <= nd_reg[DIDX_W-1:0];
                        if (quotient != '0 && nd_reg < DCNT_W'(MAX_DIGITS - 1))
                        begin
                            state_reg <= ST_START;
                        end
                        else if (neg_reg)
                        begin
                            state_reg <= ST_SIGN;
                        end
                        else
                        begin
                            state_reg <= ST_EMIT;
                        end
                    end
                end
                ST_SIGN:
                begin
                    if (out_take)
                    begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (out_take)
                    begin
                        if (rd_reg == '0)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            rd_reg <= rd_reg - 1'b1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // divider is never restarted while a division is running
    assert property (@(posedge clk) disable iff (!rst_n) div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    // a finished division always leaves a remainder below the radix
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WAIT && div_stat.done) |-> ({1'b0, remainder} < radix_reg))
        else $error("remainder not below radix");

    // the digit count never passes the store depth
    assert property (@(posedge clk) disable iff (!rst_n) nd_reg <= DCNT_W'(MAX_DIGITS))
        else $error("digit count overflow");

    // after the last character is taken the block is free for the next number
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_take && text_out.final_char) |=> num_in.ready)
        else $error("not ready after final character");

endmodule

`default_nettype wire

// ===== tb/sv/signed_int_to_radix_digits_top_tb.sv =====
// testbench for the signed integer to radix digits block: directed and random numbers over many alphabets
`timescale 1ns / 100ps

module signed_int_to_radix_digits_top_tb;
    import sird_pkg::*;

    localparam int       MAX_SYMBOLS      = 16;
    localparam int       HOLD_OFF_CYCLES  = 1300;
    localparam int       CYCLE_LIMIT      = 3_000_000;
    localparam int       RANDOM_PHASES    = 12;
    localparam int       NUMS_PER_PHASE   = 24;
    localparam int       MAX_PRINTED      = 40;
    localparam cfg_idx_t REG_UNUSED_FIRST = 8'd2;
    localparam cfg_idx_t REG_UNUSED_LAST  = 8'hFF;
    localparam num_t     NUM_MOST_NEG     = 32'h8000_0000;
    localparam num_t     NUM_MOST_POS     = 32'h7FFF_FFFF;

    typedef logic [8*MAX_SYMBOLS-1:0] alphabet_t;

    typedef struct packed {
        char_t ch;
        logic  last;
    } text_word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    sird_num_if  num_if ();
    sird_char_if char_if ();
    sird_cfg_if  cfg_if ();

    signed_int_to_radix_digits_top #(.MAX_SYMBOLS(MAX_SYMBOLS)) dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .num_in   (num_if),
        .text_out (char_if),
        .cfg      (cfg_if)
    );

    // model copy of the alphabet registers
    cfg_data_t sym_low_reg = '0;
    cfg_data_t sym_high_reg = '0;

    num_t       number_queue[$];
    text_word_t text_due[$];
    text_word_t due_word;

    int src_idle_pct = 0;
    int snk_stall_pct = 0;
    int mismatch_count = 0;
    int numbers_taken = 0;
    int chars_seen = 0;
    int silent_numbers = 0;
    int phase_count = 0;
    int cycle_count = 0;

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(string what);
        if (mismatch_count < MAX_PRINTED)
        begin
            $display("mismatch at %0t: %s", $time, what);
        end
        mismatch_count++;
    endtask

    // radix of the current alphabet, zero when the alphabet is unusable
    function automatic int unsigned alphabet_radix(alphabet_t syms);
        int unsigned n;
        n = 0;
        while (n < MAX_SYMBOLS && syms[8*n +: 8] != CHAR_NUL)
        begin
            n++;
        end
        if (n < 2)
        begin
            return 0;
        end
        for (int i = 0; i < n; i++)
        begin
            if (syms[8*i +: 8] == CHAR_PLUS || syms[8*i +: 8] == CHAR_MINUS)
            begin
                return 0;
            end
            for (int j = i + 1; j < n; j++)
            begin
                if (syms[8*j +: 8] == syms[8*i +: 8])
                begin
                    return 0;
                end
            end
        end
        return n;
    endfunction

    // expected characters of one number, appended to text_due
    function automatic void format_number(num_t raw);
        alphabet_t   syms;
        int unsigned radix;
        num_t        mag;
        char_t       digits[$];
        syms = {sym_high_reg, sym_low_reg};
        radix = alphabet_radix(syms);
        if (radix == 0)
        begin
            silent_numbers++;
            return;
        end
        mag = raw;
        if (raw[NUM_W-1])
        begin
            mag = -raw;
            text_due.push_back('{ch: CHAR_MINUS, last: 1'b0});
        end
        do
        begin
            digits.push_front(syms[8*(mag % radix) +: 8]);
            mag = mag / radix;
        end
        while (mag != 0);
        foreach (digits[i])
        begin
            text_due.push_back('{ch: digits[i], last: (i == digits.size() - 1)});
        end
    endfunction

    function automatic alphabet_t pack_alphabet(string s);
        alphabet_t syms;
        syms = '0;
        for (int i = 0; i < s.len() && i < MAX_SYMBOLS; i++)
        begin
            syms[8*i +: 8] = s[i];
        end
        return syms;
    endfunction

    // distinct usable symbols, a terminator unless all slots are used, then junk that must be ignored
    function automatic alphabet_t random_alphabet(int unsigned len);
        alphabet_t syms;
        bit        used[256];
        char_t     c;
        syms = {$urandom, $urandom, $urandom, $urandom};
        for (int i = 0; i < len; i++)
        begin
            do
            begin
                c = char_t'($urandom_range(1, 255));
            end
            while (used[c] || c == CHAR_PLUS || c == CHAR_MINUS);
            used[c] = 1'b1;
            syms[8*i +: 8] = c;
        end
        if (len < MAX_SYMBOLS)
        begin
            syms[8*len +: 8] = CHAR_NUL;
        end
        return syms;
    endfunction

    function automatic num_t random_number();
        case ($urandom_range(0, 5))
            0: return num_t'($urandom_range(0, 40));
            1: return -num_t'($urandom_range(0, 40));
            2:
            begin
                case ($urandom_range(0, 3))
                    0: return NUM_MOST_NEG;
                    1: return NUM_MOST_POS;
                    2: return '0;
                    default: return '1;
                endcase
            end
            default: return num_t'($urandom);
        endcase
    endfunction

    // one configuration word, called on a rising edge
    task automatic write_reg(cfg_idx_t idx, cfg_data_t val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        if (idx == REG_SYMBOLS_LOW)
        begin
            sym_low_reg = val;
        end
        else if (idx == REG_SYMBOLS_HIGH)
        begin
            sym_high_reg = val;
        end
        @(posedge clk);
    endtask

    // new alphabet and idling mode for the next phase
    task automatic start_phase(alphabet_t syms);
        write_reg(REG_SYMBOLS_LOW, syms[CFG_DATA_W-1:0]);
        write_reg(REG_SYMBOLS_HIGH, syms[2*CFG_DATA_W-1:CFG_DATA_W]);
        case (phase_count % 4)
            0:
            begin
                src_idle_pct = 0;
                snk_stall_pct = 0;
            end
            1:
            begin
                src_idle_pct = 48;
                snk_stall_pct = 0;
            end
            2:
            begin
                src_idle_pct = 0;
                snk_stall_pct = 48;
            end
            default:
            begin
                src_idle_pct = 38;
                snk_stall_pct = 38;
            end
        endcase
        phase_count++;
    endtask

    // wait for all numbers taken and all text seen, then let the block go idle
    task automatic settle();
        while (number_queue.size() != 0 || num_if.valid || text_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
    endtask

    // number word driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_if.valid <= 1'b0;
        end
        else
        begin
            if (num_if.valid && num_if.ready)
            begin
                numbers_taken++;
                format_number(num_if.number_value);
            end
            if (!num_if.valid || num_if.ready)
            begin
                if (number_queue.size() != 0 && $urandom_range(0, 99) >= src_idle_pct)
                begin
                    num_if.number_value <= number_queue.pop_front();
                    num_if.valid <= 1'b1;
                end
                else
                begin
                    num_if.valid <= 1'b0;
                end
            end
        end
    end

    // character word monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_if.ready <= 1'b0;
        end
        else
        begin
            if (char_if.valid && char_if.ready)
            begin
                chars_seen++;
                if (text_due.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected char %h final %b",
                                              char_if.text_char, char_if.final_char));
                end
                else
                begin
                    due_word = text_due.pop_front();
                    if (char_if.text_char !== due_word.ch)
                    begin
                        report_mismatch($sformatf("text_char %h, expected %h",
                                                  char_if.text_char, due_word.ch));
                    end
                    if (char_if.final_char !== due_word.last)
                    begin
                        report_mismatch($sformatf("final_char %b, expected %b on char %h",
                                                  char_if.final_char, due_word.last, due_word.ch));
                    end
                end
            end
            char_if.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d chars still due", cycle_count, text_due.size());
            $display("tb: failure");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        alphabet_t syms;
        int unsigned len;
        num_if.valid = 1'b0;
        num_if.number_value = '0;
        char_if.ready = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = REG_SYMBOLS_LOW;
        cfg_if.data = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset alphabet is empty, so the number stays silent
        number_queue.push_back(num_t'(5));
        settle();

        // decimal, with writes to unused indexes that must change nothing
        start_phase(pack_alphabet("0123456789"));
        write_reg(REG_UNUSED_FIRST, {$urandom, $urandom});
        write_reg(REG_UNUSED_LAST, {$urandom, $urandom});
        number_queue = '{num_t'(0), num_t'(1), -num_t'(1), num_t'(9), num_t'(10), -num_t'(10),
                         NUM_MOST_POS, NUM_MOST_NEG, num_t'(1000000000), -num_t'(123456789)};
        settle();

        // binary: the longest text
        start_phase(pack_alphabet("01"));
        number_queue = '{num_t'(0), NUM_MOST_NEG, -num_t'(1)};
        settle();

        // sixteen symbols with no terminator
        start_phase(pack_alphabet("0123456789abcdef"));
        number_queue = '{NUM_MOST_POS, NUM_MOST_NEG, num_t'(255)};
        settle();

        // unusable alphabets: too short, minus, plus, repeated symbol
        start_phase(pack_alphabet("0"));
        number_queue.push_back(num_t'(7));
        settle();
        start_phase(pack_alphabet("01-"));
        number_queue.push_back(-num_t'(7));
        settle();
        start_phase(pack_alphabet("+01"));
        number_queue.push_back(num_t'(3));
        settle();
        start_phase(pack_alphabet("0120"));
        number_queue.push_back(num_t'(12));
        settle();

        // junk after the terminator is ignored
        syms = {$urandom, $urandom, $urandom, $urandom};
        syms[23:0] = {CHAR_NUL, 8'h62, 8'h61};
        start_phase(syms);
        number_queue = '{num_t'(6), -num_t'(5)};
        settle();

        // random alphabets and numbers, now and then raw register contents
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            if (p % 6 == 5)
            begin
                syms = {$urandom, $urandom, $urandom, $urandom};
            end
            else
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    len = ($urandom_range(0, 1) == 0) ? 2 : MAX_SYMBOLS;
                end
                else
                begin
                    len = $urandom_range(2, MAX_SYMBOLS);
                end
                syms = random_alphabet(len);
            end
            start_phase(syms);
            for (int i = 0; i < NUMS_PER_PHASE; i++)
            begin
                number_queue.push_back(random_number());
            end
            settle();
        end

        $display("summary: %0d numbers over %0d alphabet phases, %0d characters checked",
                 numbers_taken, phase_count, chars_seen);
        $display("summary: %0d numbers silent under unusable alphabets, %0d mismatches",
                 silent_numbers, mismatch_count);
        if (mismatch_count == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
